// ----- rtl/ssg_pkg.sv -----
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants of the step / sine / square generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned DUTY_W    = 17;
  localparam int unsigned PHASE_W   = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVATION = 3'd4;

  typedef enum logic [1:0] {
    MODE_STEP   = 2'd0,
    MODE_SINE   = 2'd1,
    MODE_SQUARE = 2'd2
  } wave_mode_e;

  // Quarter-wave polynomial constants in Q16.
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;

  localparam logic [15:0] Q15_MAX = 16'd32767;

  // Per-word decisions carried down the pipeline.
  typedef struct packed {
    logic step_hit;
    logic sq_hit;
  } hit_t;

endpackage

// ----- rtl/ssg_div.sv -----
// ----------------------------------------------------------------------------
// ssg_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ssg_div import ssg_pkg::*; #(
  parameter int unsigned N      = 32,
  parameter int unsigned SIDE_W = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [PERIOD_W-1:0] divisor_i,
  input  logic [PERIOD_W-1:0] rem_i,
  input  logic [N-1:0]        word_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [PERIOD_W-1:0] rem_o,
  output logic [N-1:0]        word_o,
  output logic [SIDE_W-1:0]   side_o
);

  // The word register holds the dividend bits still to be consumed in its
  // upper part and collects quotient bits at the bottom.
  logic [N-1:0]        valid_q;
  logic [PERIOD_W-1:0] rem_q  [N];
  logic [N-1:0]        word_q [N];
  logic [SIDE_W-1:0]   side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                v_in;
    logic [PERIOD_W-1:0] rem_in;
    logic [N-1:0]        word_in;
    logic [SIDE_W-1:0]   side_in;
    logic [PERIOD_W:0]   trial;
    logic                qbit;
    logic [PERIOD_W-1:0] rem_d;
    logic [N-1:0]        word_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rem_i;
      assign word_in = word_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign word_in = word_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial  = {rem_in, word_in[N-1]};
    assign qbit   = (trial >= {1'b0, divisor_i});
    assign rem_d  = qbit ? PERIOD_W'(trial - {1'b0, divisor_i}) : trial[PERIOD_W-1:0];
    assign word_d = {word_in[N-2:0], qbit};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        word_q[k] <= word_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign rem_o   = rem_q[N-1];
  assign word_o  = word_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ----- rtl/ssg_sine.sv -----
// ----------------------------------------------------------------------------
// ssg_sine
// Quarter-wave polynomial sine, amplitude scaling, rounding and saturation.
// ----------------------------------------------------------------------------
module ssg_sine import ssg_pkg::*; #(
  parameter int unsigned AMP_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [PHASE_W-1:0]          phase_i,
  input  hit_t                        side_i,
  input  logic signed [AMP_WIDTH-1:0] amp_i,
  output logic                        valid_o,
  output hit_t                        side_o,
  output logic signed [AMP_WIDTH-1:0] sine_o
);

  localparam int unsigned PROD_W = AMP_WIDTH + 17;
  localparam int unsigned PW     = AMP_WIDTH + 18;
  localparam logic signed [PW-1:0] HALF = PW'(16384);
  localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

  logic [6:0] v_q;
  hit_t       side_q [7];

  // Stage 1: fold the phase into a quarter wave.
  logic [1:0]  quad;
  logic [13:0] rem14;
  logic [14:0] z;
  logic [16:0] zq1_d, zq1_q;
  logic [1:0]  quad1_q;
  assign quad  = phase_i[15:14];
  assign rem14 = phase_i[13:0];
  assign z     = quad[0] ? 15'(15'd16384 - {1'b0, rem14}) : {1'b0, rem14};
  assign zq1_d = {z, 2'b00};

  // Stage 2: z squared.
  logic [33:0] m2;
  logic [16:0] z2_2_d, z2_2_q, zq2_q;
  logic [1:0]  quad2_q;
  assign m2     = zq1_q * zq1_q;
  assign z2_2_d = 17'((m2 + 34'd32768) >> 16);

  // Stage 3: inner term B - C*z^2.
  logic [29:0] m3;
  logic [12:0] i1;
  logic [15:0] i2_d, i2_q;
  logic [16:0] z2_3_q, zq3_q;
  logic [1:0]  quad3_q;
  assign m3   = SIN_C * z2_2_q;
  assign i1   = 13'((m3 + 30'd32768) >> 16);
  assign i2_d = 16'(SIN_B - {3'b000, i1});

  // Stage 4: A - z^2*(B - C*z^2).
  logic [32:0] m4;
  logic [15:0] i3;
  logic [16:0] poly_d, poly_q, zq4_q;
  logic [1:0]  quad4_q;
  assign m4     = z2_3_q * i2_q;
  assign i3     = 16'((m4 + 33'd32768) >> 16);
  assign poly_d = SIN_A - {1'b0, i3};

  // Stage 5: final product, halve to Q1.15, clamp and apply the sign.
  logic [33:0] m5;
  logic [16:0] f;
  logic [17:0] s_sum;
  logic [16:0] s;
  logic [15:0] s_c;
  logic signed [16:0] sv_d, sv_q;
  assign m5    = zq4_q * poly_q;
  assign f     = 17'((m5 + 34'd32768) >> 16);
  assign s_sum = {1'b0, f} + 18'd1;
  assign s     = s_sum[17:1];
  assign s_c   = (s > {1'b0, Q15_MAX}) ? Q15_MAX : s[15:0];
  assign sv_d  = quad4_q[1] ? -$signed({1'b0, s_c}) : $signed({1'b0, s_c});

  // Stage 6: scale by the amplitude.
  logic signed [PROD_W-1:0] prod_d, prod_q;
  assign prod_d = amp_i * sv_q;

  // Stage 7: round to nearest with ties up, then saturate.
  logic signed [PW-1:0] biased, shifted;
  logic signed [AMP_WIDTH-1:0] sine_d, sine_q;
  assign biased  = PW'(prod_q) + HALF;
  assign shifted = biased >>> 15;
  always_comb begin
    if (shifted > SMAX) begin
      sine_d = SMAX[AMP_WIDTH-1:0];
    end else if (shifted < SMIN) begin
      sine_d = SMIN[AMP_WIDTH-1:0];
    end else begin
      sine_d = shifted[AMP_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < 7; i++) begin
        side_q[i] <= side_q[i-1];
      end
      zq1_q   <= zq1_d;
      quad1_q <= quad;
      z2_2_q  <= z2_2_d;
      zq2_q   <= zq1_q;
      quad2_q <= quad1_q;
      i2_q    <= i2_d;
      z2_3_q  <= z2_2_q;
      zq3_q   <= zq2_q;
      quad3_q <= quad2_q;
      poly_q  <= poly_d;
      zq4_q   <= zq3_q;
      quad4_q <= quad3_q;
      sv_q    <= sv_d;
      prod_q  <= prod_d;
      sine_q  <= sine_d;
    end
  end

  assign valid_o = v_q[6];
  assign side_o  = side_q[6];
  assign sine_o  = sine_q;

endmodule

// ----- rtl/ssg_outbuf.sv -----
// ----------------------------------------------------------------------------
// ssg_outbuf
// Output register with a skid entry that decouples the pipeline from stalls.
// ----------------------------------------------------------------------------
module ssg_outbuf import ssg_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         en_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [W-1:0] out_data_o
);

  logic         out_v_q, out_v_d;
  logic [W-1:0] out_q, out_d;
  logic         skid_v_q, skid_v_d;
  logic [W-1:0] skid_q, skid_d;

  // The pipeline moves only while the skid entry is free.
  assign en_o = !skid_v_q;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (out_v_q && out_stall_i) begin
      if (!skid_v_q && valid_i) begin
        skid_v_d = 1'b1;
        skid_d   = data_i;
      end
    end else if (skid_v_q) begin
      out_v_d  = 1'b1;
      out_d    = skid_q;
      skid_v_d = 1'b0;
    end else begin
      out_v_d = valid_i;
      out_d   = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/step_sine_square_generator_unit.sv -----
// ----------------------------------------------------------------------------
// step_sine_square_generator_unit
// Step, sine and square waveform generator: one signed Q8.8 sample per time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i/in_stall_o   | time_ticks_i
//  out     | output    | out_valid_o/out_stall_i | sample_value_o
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One word is accepted per cycle while in_stall_o is low. Stages: one
// per bit of time for time mod period, 16 stages for the phase
// quotient, seven for the sine polynomial and scaling, one output register.
// Reset clears all valid bits and loads the register reset values.
// A stall at the output is absorbed by a one-word skid entry; the input
// stalls only while that entry is occupied.
// ----------------------------------------------------------------------------
module step_sine_square_generator_unit import ssg_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned AMP_WIDTH  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [TIME_WIDTH-1:0]       time_ticks_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [AMP_WIDTH-1:0] sample_value_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [((TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W)-1:0] cfg_data_i
);

  // Configuration registers.
  logic [1:0]                  mode_q;
  logic signed [AMP_WIDTH-1:0] amp_q;
  logic [PERIOD_W-1:0]         period_q;
  logic [DUTY_W-1:0]           duty_q;
  logic [TIME_WIDTH-1:0]       act_q;
  logic [PERIOD_W+DUTY_W-1:0]  duty_prod_q, duty_prod_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_STEP;
      amp_q    <= '0;
      period_q <= PERIOD_W'(1);
      duty_q   <= DUTY_W'(32768);
      act_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WAVE_MODE:  mode_q   <= cfg_data_i[1:0];
        REG_AMPLITUDE:  amp_q    <= cfg_data_i[AMP_WIDTH-1:0];
        REG_PERIOD:     period_q <= cfg_data_i[PERIOD_W-1:0];
        REG_DUTY:       duty_q   <= cfg_data_i[DUTY_W-1:0];
        REG_ACTIVATION: act_q    <= cfg_data_i[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Square threshold, recomputed every cycle from the static registers.
  assign duty_prod_d = duty_q * period_q;
  always_ff @(posedge clk_i) begin
    duty_prod_q <= duty_prod_d;
  end

  logic en;
  assign in_stall_o = !en;

  // Time mod period.
  hit_t                  hit_in, hit_mod, hit_ph, hit_sin;
  logic                  v_mod, v_ph, v_sin;
  logic [PERIOD_W-1:0]   rem_mod, rem_ph;
  logic [TIME_WIDTH-1:0] quo_mod;
  logic [PHASE_W-1:0]    phase;

  assign hit_in.step_hit = (time_ticks_i >= act_q);
  assign hit_in.sq_hit   = 1'b0;

  ssg_div #(.N(TIME_WIDTH), .SIDE_W($bits(hit_t))) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .divisor_i (period_q),
    .rem_i     ('0),
    .word_i    (time_ticks_i),
    .side_i    (hit_in),
    .valid_o   (v_mod),
    .rem_o     (rem_mod),
    .word_o    (quo_mod),
    .side_o    (hit_mod)
  );

  // The quotient is not needed; only the remainder moves on.
  logic quo_unused;
  assign quo_unused = ^quo_mod;

  hit_t hit_sq;
  assign hit_sq.step_hit = hit_mod.step_hit;
  assign hit_sq.sq_hit   = ({1'b0, rem_mod, {PHASE_W{1'b0}}} < duty_prod_q) | (quo_unused & 1'b0);

  ssg_div #(.N(PHASE_W), .SIDE_W($bits(hit_t))) u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v_mod),
    .divisor_i (period_q),
    .rem_i     (rem_mod),
    .word_i    ('0),
    .side_i    (hit_sq),
    .valid_o   (v_ph),
    .rem_o     (rem_ph),
    .word_o    (phase),
    .side_o    (hit_ph)
  );

  logic [AMP_WIDTH-1:0] sine_val;
  logic rem_ph_unused;
  assign rem_ph_unused = ^rem_ph;

  ssg_sine #(.AMP_WIDTH(AMP_WIDTH)) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_ph),
    .phase_i (phase),
    .side_i  (hit_ph),
    .amp_i   (amp_q),
    .valid_o (v_sin),
    .side_o  (hit_sin),
    .sine_o  (sine_val)
  );

  logic                 period_nz;
  logic [AMP_WIDTH-1:0] sample;
  assign period_nz = (period_q != '0) | (rem_ph_unused & 1'b0);

  always_comb begin
    case (mode_q)
      MODE_STEP:   sample = hit_sin.step_hit ? amp_q : '0;
      MODE_SINE:   sample = period_nz ? sine_val : '0;
      MODE_SQUARE: sample = (period_nz && hit_sin.sq_hit) ? amp_q : '0;
      default:     sample = '0;
    endcase
  end

  ssg_outbuf #(.W(AMP_WIDTH)) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v_sin),
    .data_i      (sample),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (sample_value_o)
  );

`ifndef SYNTHESIS
  // The input stalls only while a word waits in the skid entry.
  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending output word");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("skid entry filled without an output stall");

  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !out_stall_i) |=> !in_stall_o)
    else $error("skid entry not drained after output word taken");
`endif

endmodule
